FILE: rtl/muvda_pkg.sv
package muvda_pkg;

  localparam int DET_W      = 3;
  localparam int SEC_W      = 32;
  localparam int NSEC_W     = 30;
  localparam int STRENGTH_W = 32;
  localparam int WIN_W      = 30;
  localparam int THR_W      = 32;
  localparam int PROD_W     = SEC_W + NSEC_W;
  localparam int TIME_W     = 63;
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 136;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [NSEC_W-1:0] NS_PER_SECOND = 30'd1_000_000_000;
  localparam logic [TIME_W-1:0] TIME_MAX      = {TIME_W{1'b1}};

  localparam logic [DET_W-1:0] POOL_DET_LOW  = 3'd5;
  localparam logic [DET_W-1:0] POOL_DET_HIGH = 3'd6;

  localparam logic [WIN_W-1:0] WIN_WATER_POOL_RST = 30'd602000;
  localparam logic [WIN_W-1:0] WIN_AD_RST         = 30'd1402000;
  localparam logic [WIN_W-1:0] WIN_SHOWER_RST     = 30'd400400000;
  localparam logic [THR_W-1:0] THR_WATER_POOL_RST = 32'd3072;
  localparam logic [THR_W-1:0] THR_AD_RST         = 32'd768000;
  localparam logic [THR_W-1:0] THR_SHOWER_RST     = 32'd76800000;
  localparam logic [DET_W-1:0] TARGET_DET_RST     = 3'd1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WIN_WATER_POOL = 3'd0,
    REG_WIN_AD         = 3'd1,
    REG_WIN_SHOWER     = 3'd2,
    REG_THR_WATER_POOL = 3'd3,
    REG_THR_AD         = 3'd4,
    REG_THR_SHOWER     = 3'd5,
    REG_TARGET_DET     = 3'd6
  } cfg_index_t;

  typedef enum logic [1:0] {
    CLASS_NONE       = 2'd0,
    CLASS_WATER_POOL = 2'd1,
    CLASS_AD         = 2'd2,
    CLASS_SHOWER     = 2'd3
  } muon_class_t;

  typedef struct packed {
    logic [WIN_W-1:0] win_water_pool;
    logic [WIN_W-1:0] win_ad;
    logic [WIN_W-1:0] win_shower;
    logic [THR_W-1:0] thr_water_pool;
    logic [THR_W-1:0] thr_ad;
    logic [THR_W-1:0] thr_shower;
    logic [DET_W-1:0] target_det;
  } cfg_t;

  typedef struct packed {
    muon_class_t       cls;
    logic [TIME_W-1:0] t_ns;
    logic [TIME_W-1:0] end_ns;
    logic [WIN_W-1:0]  win;
  } item_t;

endpackage

FILE: rtl/muvda_cfg_regs.sv
module muvda_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [muvda_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [muvda_pkg::CFG_DATA_W-1:0]     cfg_data,
  output muvda_pkg::cfg_t                      cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.win_water_pool <= muvda_pkg::WIN_WATER_POOL_RST;
      cfg.win_ad         <= muvda_pkg::WIN_AD_RST;
      cfg.win_shower     <= muvda_pkg::WIN_SHOWER_RST;
      cfg.thr_water_pool <= muvda_pkg::THR_WATER_POOL_RST;
      cfg.thr_ad         <= muvda_pkg::THR_AD_RST;
      cfg.thr_shower     <= muvda_pkg::THR_SHOWER_RST;
      cfg.target_det     <= muvda_pkg::TARGET_DET_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        muvda_pkg::REG_WIN_WATER_POOL: cfg.win_water_pool <= cfg_data[muvda_pkg::WIN_W-1:0];
        muvda_pkg::REG_WIN_AD:         cfg.win_ad         <= cfg_data[muvda_pkg::WIN_W-1:0];
        muvda_pkg::REG_WIN_SHOWER:     cfg.win_shower     <= cfg_data[muvda_pkg::WIN_W-1:0];
        muvda_pkg::REG_THR_WATER_POOL: cfg.thr_water_pool <= cfg_data[muvda_pkg::THR_W-1:0];
        muvda_pkg::REG_THR_AD:         cfg.thr_ad         <= cfg_data[muvda_pkg::THR_W-1:0];
        muvda_pkg::REG_THR_SHOWER:     cfg.thr_shower     <= cfg_data[muvda_pkg::THR_W-1:0];
        muvda_pkg::REG_TARGET_DET:     cfg.target_det     <= cfg_data[muvda_pkg::DET_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: rtl/muvda_front.sv
module muvda_front (
  input  logic                                clk,
  input  logic                                rst,
  input  muvda_pkg::cfg_t                     cfg,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [muvda_pkg::IN_TDATA_W-1:0]    s_tdata,
  output muvda_pkg::item_t                    item,
  output logic                                item_valid,
  input  logic                                item_ready
);

  logic                                 a_valid;
  logic [muvda_pkg::DET_W-1:0]          a_det;
  logic [muvda_pkg::SEC_W-1:0]          a_sec;
  logic [muvda_pkg::NSEC_W-1:0]         a_nsec;
  logic [muvda_pkg::STRENGTH_W-1:0]     a_strength;

  logic                                 b_valid;
  muvda_pkg::muon_class_t               b_cls;
  logic [muvda_pkg::PROD_W-1:0]         b_prod;
  logic [muvda_pkg::NSEC_W-1:0]         b_nsec;
  logic [muvda_pkg::NSEC_W:0]           b_nsec_win;
  logic [muvda_pkg::WIN_W-1:0]          b_win;

  logic                                 c_valid;

  logic                                 a_ready;
  logic                                 b_ready;
  logic                                 c_ready;

  muvda_pkg::muon_class_t               cls;
  logic [muvda_pkg::WIN_W-1:0]          win;
  logic                                 is_pool_det;
  logic                                 is_target_det;

  // Each stage takes a new request when it is empty or its contents move on.
  assign c_ready  = !c_valid || item_ready;
  assign b_ready  = !b_valid || c_ready;
  assign a_ready  = !a_valid || b_ready;
  assign s_tready = a_ready;

  assign is_pool_det   = (a_det == muvda_pkg::POOL_DET_LOW) || (a_det == muvda_pkg::POOL_DET_HIGH);
  assign is_target_det = (a_det == cfg.target_det);

  always_comb begin
    cls = muvda_pkg::CLASS_NONE;
    win = '0;
    if (is_pool_det && (a_strength > cfg.thr_water_pool)) begin
      cls = muvda_pkg::CLASS_WATER_POOL;
      win = cfg.win_water_pool;
    end else if (is_target_det && (a_strength > cfg.thr_shower)) begin
      cls = muvda_pkg::CLASS_SHOWER;
      win = cfg.win_shower;
    end else if (is_target_det && (a_strength > cfg.thr_ad)) begin
      cls = muvda_pkg::CLASS_AD;
      win = cfg.win_ad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= s_tvalid;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
      if (c_ready) begin
        c_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && s_tvalid) begin
      a_det      <= s_tdata[2:0];
      a_sec      <= s_tdata[34:3];
      a_nsec     <= s_tdata[64:35];
      a_strength <= s_tdata[96:65];
    end
    if (b_ready && a_valid) begin
      b_cls      <= cls;
      b_prod     <= muvda_pkg::PROD_W'(a_sec) * muvda_pkg::PROD_W'(muvda_pkg::NS_PER_SECOND);
      b_nsec     <= a_nsec;
      b_nsec_win <= (muvda_pkg::NSEC_W+1)'(a_nsec) + (muvda_pkg::NSEC_W+1)'(win);
      b_win      <= win;
    end
    if (c_ready && b_valid) begin
      item.cls    <= b_cls;
      item.t_ns   <= muvda_pkg::TIME_W'(b_prod) + muvda_pkg::TIME_W'(b_nsec);
      item.end_ns <= muvda_pkg::TIME_W'(b_prod) + muvda_pkg::TIME_W'(b_nsec_win);
      item.win    <= b_win;
    end
  end

  assign item_valid = c_valid;

endmodule

FILE: rtl/muvda_union.sv
module muvda_union (
  input  logic                                clk,
  input  logic                                rst,
  input  muvda_pkg::item_t                    item,
  input  logic                                item_valid,
  output logic                                item_ready,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [muvda_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  localparam int PAD_W = muvda_pkg::OUT_TDATA_W - 3 - 2 * muvda_pkg::TIME_W;

  logic [muvda_pkg::TIME_W-1:0]  last_end;
  logic [muvda_pkg::TIME_W-1:0]  total;
  logic [muvda_pkg::TIME_W-1:0]  last_end_next;
  logic [muvda_pkg::TIME_W-1:0]  total_next;
  logic [muvda_pkg::WIN_W-1:0]   add;
  logic [muvda_pkg::TIME_W:0]    sum;
  logic                          extended;

  assign item_ready = !m_tvalid || m_tready;

  // Only the part of the new window past the current union end is counted.
  always_comb begin
    extended = (item.cls != muvda_pkg::CLASS_NONE) && (item.end_ns > last_end);
    if (item.t_ns < last_end) begin
      add = muvda_pkg::WIN_W'(item.end_ns - last_end);
    end else begin
      add = item.win;
    end
    sum = (muvda_pkg::TIME_W+1)'(total) + (muvda_pkg::TIME_W+1)'(add);
    if (extended) begin
      last_end_next = item.end_ns;
      total_next    = sum[muvda_pkg::TIME_W] ? muvda_pkg::TIME_MAX : sum[muvda_pkg::TIME_W-1:0];
    end else begin
      last_end_next = last_end;
      total_next    = total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      last_end <= '0;
      total    <= '0;
    end else if (item_ready) begin
      m_tvalid <= item_valid;
      if (item_valid) begin
        last_end <= last_end_next;
        total    <= total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      m_tdata <= {PAD_W'(0), total_next, last_end_next, extended, item.cls};
    end
  end

endmodule

FILE: rtl/muon_veto_deadtime_accumulator.sv
// One request per cycle; the input, multiply, time-sum and window-union registers
// form a four-stage pipeline that stalls only when the output is not taken.
// Reset (rst, synchronous, active high) restores the default register values and
// clears the veto end, the accumulated veto time and all valid flags.
module muon_veto_deadtime_accumulator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // muon_detector[2:0], trigger_seconds[34:3], trigger_nanoseconds[64:35],
  // muon_strength[96:65], zero fill above
  input  logic [muvda_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // muon_class[1:0], window_extended[2], veto_end_ns[65:3],
  // total_veto_ns[128:66], zero fill above
  output logic [muvda_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [muvda_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [muvda_pkg::CFG_DATA_W-1:0]    cfg_data
);

  muvda_pkg::cfg_t   cfg;
  muvda_pkg::item_t  item;
  logic              item_valid;
  logic              item_ready;

  muvda_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  muvda_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready)
  );

  muvda_union u_union (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

FILE: rtl/muvda_checker.sv
module muvda_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  input  logic                                s_tready,
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic [muvda_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  logic                          seen;
  logic [muvda_pkg::TIME_W-1:0]  prev_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      prev_total <= m_tdata[128:66];
    end
  end

  // A result that is not taken stays offered.
  assert property (@(posedge clk) disable iff (rst) m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A trigger without a class never moves the veto end.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == muvda_pkg::CLASS_NONE) |-> !m_tdata[2])
    else $error("unclassified trigger extended the window");

  // The accumulated veto time never decreases from one result to the next.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && seen |-> m_tdata[128:66] >= prev_total)
    else $error("accumulated veto time decreased");

  // An empty pipeline with an idle output always takes a new request.
  assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && !m_tvalid && $past(!m_tvalid) && $past(!s_tvalid, 1) &&
    $past(!s_tvalid, 2) && $past(!s_tvalid, 3) |-> s_tready)
    else $error("input stalled with an empty pipeline");

endmodule

bind muon_veto_deadtime_accumulator muvda_checker u_muvda_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
